/* hw/rtl/lurd_pkg.sv */
// ----------------------------------------------------------------------------
// lurd_pkg
// Shared constants and sequencer state type for the uniform range draw block.
// ----------------------------------------------------------------------------
`default_nettype none

package lurd_pkg;

	localparam int          FIELD_W    = 15;
	localparam int          LCG_W      = 32;
	localparam logic [31:0] LCG_MUL    = 32'd1103515245;
	localparam logic [31:0] LCG_INC    = 32'd12345;
	localparam logic [31:0] LCG_RESET  = 32'd1;
	localparam int          DRAW_SHIFT = 16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETUP,
		S_DIV1,
		S_DRAW,
		S_CHECK,
		S_DIV2,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/lurd_lcg.sv */
// ----------------------------------------------------------------------------
// lurd_lcg
// 32-bit linear congruential generator, seed load, one step per cycle on step.
// ----------------------------------------------------------------------------
`default_nettype none

module lurd_lcg #(
	parameter int RAND_BITS = 15
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 seed_we,
	input  wire logic [31:0]          seed,
	input  wire logic                 step,
	output logic      [RAND_BITS-1:0] draw
);
	import lurd_pkg::*;

	logic [LCG_W-1:0] state_q;
	logic [LCG_W-1:0] state_nxt;

	assign state_nxt = state_q * LCG_MUL + LCG_INC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LCG_RESET;
		end else if (seed_we) begin
			state_q <= seed;
		end else if (step) begin
			state_q <= state_nxt;
		end
	end

	assign draw = state_q[DRAW_SHIFT +: RAND_BITS];

endmodule

`default_nettype wire

/* hw/rtl/lurd_div.sv */
// ----------------------------------------------------------------------------
// lurd_div
// Restoring divider, one quotient bit per cycle; done pulses with results.
// ----------------------------------------------------------------------------
`default_nettype none

module lurd_div #(
	parameter int W = 15
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic      [W-1:0] quo,
	output logic      [W-1:0] rem
);
	import lurd_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [W:0]    shifted;
	logic          ge;
	logic [W:0]    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : shifted[W-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* hw/rtl/lcg_uniform_range_draw.sv */
// ----------------------------------------------------------------------------
// lcg_uniform_range_draw
// Unbiased uniform integer between two bounds from a 32-bit LCG, by rejection.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries low_bound and high_bound; the
//   order of the bounds does not matter. One transaction is taken at a time:
//   in_stall stays high from acceptance until the result is in the output
//   register. Output channel (out_valid/out_stall) carries value from a
//   register that holds while out_stall is high.
//   Equal bounds go straight to the result. A span at least as wide as the
//   draw range of RAND_BITS bits takes a single draw and skips the divider;
//   otherwise the serial divider runs once for the bucket size and once for
//   the final scaling, and each rejected draw is followed by a fresh draw.
//   cfg_we loads cfg_wdata into the generator state; write only when idle.
//   Reset loads the generator with 1 and empties the output register.
//   A stalled output holds the finished transaction and the block waits.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg_uniform_range_draw #(
	parameter int RAND_BITS = 15
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [31:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [14:0] low_bound,
	input  wire logic [14:0] high_bound,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [14:0] value
);
	import lurd_pkg::*;

	localparam int                 RB   = RAND_BITS;
	localparam logic [RB-1:0]      RMAX = '1;

	state_t state_q, state_nxt;

	logic [FIELD_W-1:0] lo_q, hi_q, res_q, value_q;
	logic [RB-1:0]      bucket_q, lim_q;
	logic               big_q;
	logic               out_valid_q;

	logic [FIELD_W:0]   span;
	logic               big;
	logic               accept;
	logic               draw_ok;
	logic               load_out;
	logic               div_start;
	logic               lcg_step;
	logic [RB-1:0]      draw;
	logic [RB-1:0]      div_dividend, div_divisor, div_quo, div_rem;
	logic               div_done;
	logic [FIELD_W+1:0] sum_draw, sum_quo;

	assign span     = {1'b0, hi_q} - {1'b0, lo_q} + 1'b1;
	assign big      = {1'b0, span} > (FIELD_W + 2)'(RMAX);
	assign accept   = in_valid && !in_stall;
	assign draw_ok  = draw < lim_q;
	assign sum_draw = (FIELD_W + 2)'(lo_q) + (FIELD_W + 2)'(draw);
	assign sum_quo  = (FIELD_W + 2)'(lo_q) + (FIELD_W + 2)'(div_quo);

	assign div_dividend = (state_q == S_SETUP) ? RMAX : draw;
	assign div_divisor  = (state_q == S_SETUP) ? span[RB-1:0] : bucket_q;

	lurd_lcg #(
		.RAND_BITS(RB)
	) u_lcg (
		.clk    (clk),
		.arst_n (arst_n),
		.seed_we(cfg_we),
		.seed   (cfg_wdata),
		.step   (lcg_step),
		.draw   (draw)
	);

	lurd_div #(
		.W(RB)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quo     (div_quo),
		.rem     (div_rem)
	);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_nxt = (low_bound == high_bound) ? S_DONE : S_SETUP;
			end
			S_SETUP: state_nxt = big ? S_DRAW : S_DIV1;
			S_DIV1: begin
				if (div_done)
					state_nxt = S_DRAW;
			end
			S_DRAW:  state_nxt = S_CHECK;
			S_CHECK: begin
				if (big_q)
					state_nxt = S_DONE;
				else if (draw_ok)
					state_nxt = S_DIV2;
				else
					state_nxt = S_DRAW;
			end
			S_DIV2: begin
				if (div_done)
					state_nxt = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall)
					state_nxt = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		lcg_step  = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			S_IDLE:  in_stall  = 1'b0;
			S_SETUP: div_start = !big;
			S_DRAW:  lcg_step  = 1'b1;
			S_CHECK: div_start = !big_q && draw_ok;
			S_DONE:  load_out  = !out_valid_q || !out_stall;
			default: in_stall  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q  <= (low_bound > high_bound) ? high_bound : low_bound;
			hi_q  <= (low_bound > high_bound) ? low_bound : high_bound;
			res_q <= low_bound;
		end
		if (state_q == S_SETUP)
			big_q <= big;
		if (state_q == S_DIV1 && div_done) begin
			bucket_q <= div_quo;
			lim_q    <= RMAX - div_rem;
		end
		if (state_q == S_CHECK && big_q)
			res_q <= sum_draw[FIELD_W-1:0];
		if (state_q == S_DIV2 && div_done)
			res_q <= sum_quo[FIELD_W-1:0];
		if (load_out)
			value_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;

endmodule

`default_nettype wire
